[src/mexp_pkg.sv]
package mexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0] operand_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BASE,
        ST_SQR,
        ST_MUL,
        ST_FINISH
    } state_t;

endpackage

[src/modular_exponentiation.sv]
// A zero exponent goes straight to the output register. Otherwise the base is reduced,
// then each exponent bit takes a square and, if set, a multiply. A stalled output
// register holds back the result.
// One transaction at a time: in_stall stays high until result_reg is loaded.
// Each modular multiply runs one shared add/compare-subtract unit, bit by bit.
// Reset (rst_n low, asynchronous) idles the sequencer, empties the output register
// and sets the modulus to 1.
module modular_exponentiation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] base,
    input  logic [31:0] exponent,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] power_result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] modulus
);
    import mexp_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

    state_t state_reg, state_next;

    operand_t          modulus_reg;
    operand_t          r_reg, r_next;
    operand_t          mx_reg, mx_next;
    operand_t          my_reg, my_next;
    logic              phase_reg, phase_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    operand_t          exp_reg, exp_next;
    logic [CNT_W-1:0]  ecnt_reg, ecnt_next;
    operand_t          b_reg, b_next;
    operand_t          acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    operand_t          result_reg, result_next;

    operand_t                 addend;
    logic [OPERAND_WIDTH:0]   sum;
    operand_t                 diff;
    operand_t                 red;
    logic                     mul_done;
    logic                     in_take;
    logic                     out_free;
    logic                     exp_last;

    // shared modular add: one doubling or one conditional add per cycle
    always_comb
    begin
        addend = phase_reg ? (my_reg[OPERAND_WIDTH-1] ? mx_reg : '0) : r_reg;
        sum    = {1'b0, r_reg} + {1'b0, addend};
        diff   = sum[OPERAND_WIDTH-1:0] - modulus_reg;
        if (modulus_reg == '0)
        begin
            red = sum[OPERAND_WIDTH-1:0];
        end
        else if (sum >= {1'b0, modulus_reg})
        begin
            red = diff;
        end
        else
        begin
            red = sum[OPERAND_WIDTH-1:0];
        end
    end

    assign mul_done = phase_reg && (cnt_reg == CNT_LAST);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign exp_last = (ecnt_reg == CNT_LAST);

    assign in_stall     = (state_reg != ST_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign power_result = 32'(result_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (exponent[OPERAND_WIDTH-1:0] == '0) ? ST_FINISH : ST_BASE;
                end
            end
            ST_BASE:
            begin
                if (mul_done)
                begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (mul_done)
                begin
                    if (exp_reg[OPERAND_WIDTH-1])
                    begin
                        state_next = ST_MUL;
                    end
                    else if (exp_last)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next = exp_last ? ST_FINISH : ST_SQR;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and output register
    always_comb
    begin
        r_next         = red;
        phase_next     = !phase_reg;
        cnt_next       = phase_reg ? cnt_reg + 1'b1 : cnt_reg;
        mx_next        = mx_reg;
        my_next        = phase_reg ? {my_reg[OPERAND_WIDTH-2:0], 1'b0} : my_reg;
        exp_next       = exp_reg;
        ecnt_next      = ecnt_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                r_next     = '0;
                phase_next = 1'b0;
                cnt_next   = '0;
                // reduce the base by multiplying it by one
                mx_next    = operand_t'(1);
                my_next    = base[OPERAND_WIDTH-1:0];
                exp_next   = exponent[OPERAND_WIDTH-1:0];
                ecnt_next  = '0;
                acc_next   = operand_t'(1);
            end
            ST_BASE:
            begin
                if (mul_done)
                begin
                    b_next     = red;
                    r_next     = '0;
                    phase_next = 1'b0;
                    cnt_next   = '0;
                    mx_next    = operand_t'(1);
                    my_next    = operand_t'(1);
                end
            end
            ST_SQR:
            begin
                if (mul_done)
                begin
                    acc_next   = red;
                    r_next     = '0;
                    phase_next = 1'b0;
                    cnt_next   = '0;
                    if (exp_reg[OPERAND_WIDTH-1])
                    begin
                        mx_next = b_reg;
                        my_next = red;
                    end
                    else
                    begin
                        mx_next   = red;
                        my_next   = red;
                        exp_next  = {exp_reg[OPERAND_WIDTH-2:0], 1'b0};
                        ecnt_next = ecnt_reg + 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    acc_next   = red;
                    r_next     = '0;
                    phase_next = 1'b0;
                    cnt_next   = '0;
                    mx_next    = red;
                    my_next    = red;
                    exp_next   = {exp_reg[OPERAND_WIDTH-2:0], 1'b0};
                    ecnt_next  = ecnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    result_next    = acc_reg;
                end
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            modulus_reg   <= operand_t'(1);
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
            cnt_reg       <= '0;
            ecnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            ecnt_reg      <= ecnt_next;
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg <= modulus[OPERAND_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg      <= r_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        exp_reg    <= exp_next;
        b_reg      <= b_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

endmodule

[src/mexp_checker.sv]
module mexp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] power_result
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(power_result))
        else $error("stalled result dropped or changed");

    // drop valid only after the transaction completes
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> !$past(out_stall))
        else $error("result withdrawn while stalled");

    // busy right after taking an item
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    // a new result only comes out of work in progress
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in work");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .power_result (power_result)
);

[bench/modular_exponentiation_test.sv]
module modular_exponentiation_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mexp_pkg::*;

    class power_tracker;
        operand_t modulus_value;
        operand_t pending_powers[$];
        int       errors;

        function new();
            modulus_value = 1;
            errors        = 0;
        endfunction

        function void set_modulus(operand_t m);
            modulus_value = m;
        endfunction

        // A zero modulus means plain wraparound at the operand width.
        function logic [63:0] reduce(logic [63:0] x);
            if (modulus_value == '0)
                return {{(64 - OPERAND_WIDTH){1'b0}}, x[OPERAND_WIDTH-1:0]};
            return x % {{(64 - OPERAND_WIDTH){1'b0}}, modulus_value};
        endfunction

        function operand_t modpow(operand_t b, operand_t e);
            logic [63:0] acc;
            logic [63:0] rb;
            if (e == '0)
                return operand_t'(1);
            rb  = reduce({{(64 - OPERAND_WIDTH){1'b0}}, b});
            acc = 64'd1;
            for (int i = OPERAND_WIDTH - 1; i >= 0; i--)
            begin
                acc = reduce(acc * acc);
                if (e[i])
                    acc = reduce(acc * rb);
            end
            return operand_t'(reduce(acc));
        endfunction

        function void note_operands(operand_t b, operand_t e);
            pending_powers.push_back(modpow(b, e));
        endfunction

        function void check_power(operand_t actual);
            operand_t want;
            if (pending_powers.size() == 0)
            begin
                $display("%0t: unexpected power_result: expected none, actual %h",
                         $time, actual);
                errors++;
                return;
            end
            want = pending_powers.pop_front();
            if (actual !== want)
            begin
                $display("%0t: power_result mismatch: expected %h, actual %h",
                         $time, want, actual);
                errors++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [31:0] base      = '0;
    logic [31:0] exponent  = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] power_result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] mod_data  = '0;

    bit           calm = 1'b0;
    power_tracker tracker = new();

    modular_exponentiation uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .base         (base),
        .exponent     (exponent),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .power_result (power_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .modulus      (mod_data)
    );

    always #5 clk = ~clk;

    initial
    begin
        #60_000_000;
        $display("** modular_exponentiation: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_power(power_result);
    end

    // Stall the result side in bursts, with long quiet stretches now and then.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 299) == 0)
            begin
                repeat ($urandom_range(200, 3000)) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Keep valid high across back-to-back transactions; only hold_off and drain drop it.
    task automatic send(operand_t b, operand_t e);
        in_valid <= 1'b1;
        base     <= b;
        exponent <= e;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_operands(b, e);
    endtask

    task automatic hold_off(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending_powers.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_modulus(operand_t m);
        drain();
        cfg_valid <= 1'b1;
        mod_data  <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.set_modulus(m);
    endtask

    initial
    begin
        operand_t b;
        operand_t e;
        operand_t m;
        int       sel;
        bit       sender_quiet;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset modulus of 1: zero exponent still gives 1.
        send(32'd5, 32'd0);
        send(32'd5, 32'd1);
        send(32'hFFFFFFFF, 32'hFFFFFFFF);

        write_modulus(32'hFFFFFFFB);
        send(32'd0, 32'd0);
        send(32'd0, 32'd1);
        send(32'd0, 32'hFFFFFFFF);
        send(32'hFFFFFFFF, 32'd0);
        send(32'hFFFFFFFF, 32'd1);
        send(32'hFFFFFFFF, 32'hFFFFFFFF);
        send(32'd1, 32'hFFFFFFFF);
        send(32'd2, 32'd32);
        send(32'd3, 32'd5);
        send(32'hFFFFFFFD, 32'd2);
        send(32'd12345, 32'h80000000);
        send(32'hAAAAAAAA, 32'h55555555);
        send(32'h55555555, 32'hAAAAAAAA);
        send(32'd7, 32'hFFFFFFFE);

        for (int p = 0; p < 7; p++)
        begin
            case (p)
                0:       m = 32'hFFFFFFFF;
                1:       m = 32'd2;
                2:       m = 32'd0;
                3:       m = $urandom | 32'd1;
                4:       m = $urandom_range(3, 1000);
                5:       m = 32'd1;
                default: m = $urandom;
            endcase
            write_modulus(m);
            if (p == 2)
            begin
                // Wraparound arithmetic with a zero modulus.
                send(32'd3, 32'hFFFFFFFF);
                send(32'hFFFFFFFF, 32'd2);
                send(32'd2, 32'd32);
                send(32'd2, 32'd31);
            end
            if (p == 6)
                calm = 1'b1;
            sender_quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 17; k++)
            begin
                if (p == 2 && k == 8)
                    drain();
                if (!calm && !sender_quiet && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 19));
                sel = $urandom_range(0, 9);
                case (sel)
                    6:       e = $urandom_range(0, 16);
                    7:       e = 32'd0;
                    8:       e = 32'hFFFFFFFF ^ (32'd1 << $urandom_range(0, 31));
                    9:       e = 32'd1 << $urandom_range(0, 31);
                    default: e = $urandom;
                endcase
                sel = $urandom_range(0, 9);
                case (sel)
                    7:       b = $urandom_range(0, 3);
                    8:       b = 32'hFFFFFFFF - $urandom_range(0, 3);
                    9:       b = (m != 0) ? $urandom % m : $urandom;
                    default: b = $urandom;
                endcase
                send(b, e);
            end
        end

        drain();
        repeat (10) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_powers.size() == 0)
            $display("** modular_exponentiation: PASSED **");
        else
            $display("** modular_exponentiation: FAILED **");
        $finish;
    end

endmodule
